>>> rtl/core/bbc_pkg.sv
// shared types and constants of the bracket balance checker
package bbc_pkg;

	// ascii characters of interest
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_NONE    = 8'h00;

	// operation codes passed from front to back
	localparam logic [2:0] OP_OPEN    = 3'd0;
	localparam logic [2:0] OP_CLOSE   = 3'd1;
	localparam logic [2:0] OP_NEWLINE = 3'd2;
	localparam logic [2:0] OP_EOT     = 3'd3;
	localparam logic [2:0] OP_OTHER   = 3'd4;

	// bracket kinds
	localparam logic [1:0] KIND_PAREN = 2'd0;
	localparam logic [1:0] KIND_BRACK = 2'd1;
	localparam logic [1:0] KIND_BRACE = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	// verdict codes
	localparam logic [2:0] VERDICT_BALANCED  = 3'd0;
	localparam logic [2:0] VERDICT_MISMATCH  = 3'd1;
	localparam logic [2:0] VERDICT_UNOPENED  = 3'd2;
	localparam logic [2:0] VERDICT_UNCLOSED  = 3'd3;
	localparam logic [2:0] VERDICT_TOO_DEEP  = 3'd4;

	// classified operation queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	typedef struct packed {
		logic [2:0] op;
		logic [1:0] kind;
	} bbc_op_t;

endpackage

>>> rtl/core/bbc_front.sv
// front end: accepts text bytes and classifies them into stack operations
module bbc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      text_byte,
	input  logic            end_of_text,
	output logic            op_valid,
	input  logic            op_ready,
	output bbc_pkg::bbc_op_t op_entry
);

	bbc_pkg::bbc_op_t cls;
	logic             relevant;
	logic             valid_s1;
	bbc_pkg::bbc_op_t entry_s1;

	// byte classification
	always_comb begin
		cls.op   = bbc_pkg::OP_OTHER;
		cls.kind = bbc_pkg::KIND_NONE;
		if (end_of_text) begin
			cls.op = bbc_pkg::OP_EOT;
		end else begin
			case (text_byte)
				bbc_pkg::CH_LPAREN: begin
					cls.op   = bbc_pkg::OP_OPEN;
					cls.kind = bbc_pkg::KIND_PAREN;
				end
				bbc_pkg::CH_LBRACK: begin
					cls.op   = bbc_pkg::OP_OPEN;
					cls.kind = bbc_pkg::KIND_BRACK;
				end
				bbc_pkg::CH_LBRACE: begin
					cls.op   = bbc_pkg::OP_OPEN;
					cls.kind = bbc_pkg::KIND_BRACE;
				end
				bbc_pkg::CH_RPAREN: begin
					cls.op   = bbc_pkg::OP_CLOSE;
					cls.kind = bbc_pkg::KIND_PAREN;
				end
				bbc_pkg::CH_RBRACK: begin
					cls.op   = bbc_pkg::OP_CLOSE;
					cls.kind = bbc_pkg::KIND_BRACK;
				end
				bbc_pkg::CH_RBRACE: begin
					cls.op   = bbc_pkg::OP_CLOSE;
					cls.kind = bbc_pkg::KIND_BRACE;
				end
				bbc_pkg::CH_NEWLINE: begin
					cls.op = bbc_pkg::OP_NEWLINE;
				end
				default: begin
					cls.op = bbc_pkg::OP_OTHER;
				end
			endcase
		end
	end

	// bytes with no effect never enter the queue
	assign relevant = (cls.op != bbc_pkg::OP_OTHER);
	assign in_ready = !valid_s1 || op_ready;

	// classified beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && relevant;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			entry_s1 <= cls;
		end
	end

	assign op_valid = valid_s1;
	assign op_entry = entry_s1;

endmodule

>>> rtl/core/bbc_queue.sv
// short operation queue decoupling front and back
module bbc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  bbc_pkg::bbc_op_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output bbc_pkg::bbc_op_t pop_data
);

	bbc_pkg::bbc_op_t                 slot_q [bbc_pkg::QUEUE_DEPTH];
	logic [bbc_pkg::QUEUE_AW-1:0]     wptr_q;
	logic [bbc_pkg::QUEUE_AW-1:0]     rptr_q;
	logic [bbc_pkg::QUEUE_AW:0]       level_q;
	logic                             do_push;
	logic                             do_pop;

	assign push_ready = (level_q != (bbc_pkg::QUEUE_AW + 1)'(bbc_pkg::QUEUE_DEPTH));
	assign pop_valid  = (level_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = slot_q[rptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/core/bbc_back.sv
// back end: bracket stack, line counter, error tracking and result register
module bbc_back #(
	parameter int STACK_DEPTH = 64,
	parameter int LINE_BITS   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             op_valid,
	output logic             op_ready,
	input  bbc_pkg::bbc_op_t op_entry,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       verdict,
	output logic [7:0]       expected_char,
	output logic [15:0]      error_line
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int EW = LINE_BITS + 2;

	// stack memory holds every entry; top and next-to-top are also kept at hand
	logic [EW-1:0]        stack_mem [STACK_DEPTH];
	logic [EW-1:0]        top_q;
	logic [EW-1:0]        rd_q;
	logic [CW-1:0]        count_q;
	logic [LINE_BITS-1:0] line_q;
	logic                 err_q;

	logic                 out_valid_q;
	logic [2:0]           verdict_q;
	logic [7:0]           expected_q;
	logic [15:0]          line_out_q;

	logic                 take;
	logic                 emit;
	logic [2:0]           res_verdict;
	logic [7:0]           res_expected;
	logic [15:0]          res_line;
	logic [CW-1:0]        count_d;
	logic [LINE_BITS-1:0] line_d;
	logic                 err_d;
	logic [EW-1:0]        top_d;
	logic                 push_en;
	logic [CW-1:0]        raddr_full;
	logic [AW-1:0]        raddr;
	logic [1:0]           top_kind;
	logic [LINE_BITS-1:0] top_line;
	logic                 stack_full;
	logic                 stack_empty;

	function automatic logic [7:0] closer_of(input logic [1:0] kind);
		logic [7:0] c;
		case (kind)
			bbc_pkg::KIND_PAREN: c = bbc_pkg::CH_RPAREN;
			bbc_pkg::KIND_BRACK: c = bbc_pkg::CH_RBRACK;
			bbc_pkg::KIND_BRACE: c = bbc_pkg::CH_RBRACE;
			default:             c = bbc_pkg::CH_NONE;
		endcase
		return c;
	endfunction

	function automatic logic [15:0] sat_line(input logic [LINE_BITS-1:0] v);
		logic [32:0] w;
		w = 33'(v);
		return (|w[32:16]) ? 16'hFFFF : w[15:0];
	endfunction

	assign top_kind    = top_q[EW-1:LINE_BITS];
	assign top_line    = top_q[LINE_BITS-1:0];
	assign stack_full  = (count_q == CW'(STACK_DEPTH));
	assign stack_empty = (count_q == '0);

	// one operation a cycle unless the result register is blocked
	assign op_ready = !out_valid_q || out_ready;
	assign take     = op_valid && op_ready;

	// operation execution
	always_comb begin
		emit         = 1'b0;
		res_verdict  = bbc_pkg::VERDICT_BALANCED;
		res_expected = bbc_pkg::CH_NONE;
		res_line     = '0;
		count_d      = count_q;
		line_d       = line_q;
		err_d        = err_q;
		top_d        = top_q;
		push_en      = 1'b0;
		if (take) begin
			case (op_entry.op)
				bbc_pkg::OP_EOT: begin
					if (!err_q) begin
						emit = 1'b1;
						if (!stack_empty) begin
							res_verdict  = bbc_pkg::VERDICT_UNCLOSED;
							res_expected = closer_of(top_kind);
							res_line     = sat_line(top_line);
						end
					end
					count_d = '0;
					line_d  = LINE_BITS'(1);
					err_d   = 1'b0;
				end
				bbc_pkg::OP_OPEN: begin
					if (!err_q) begin
						if (stack_full) begin
							emit        = 1'b1;
							res_verdict = bbc_pkg::VERDICT_TOO_DEEP;
							res_line    = sat_line(line_q);
							err_d       = 1'b1;
						end else begin
							push_en = 1'b1;
							top_d   = {op_entry.kind, line_q};
							count_d = count_q + CW'(1);
						end
					end
				end
				bbc_pkg::OP_CLOSE: begin
					if (!err_q) begin
						if (stack_empty) begin
							emit        = 1'b1;
							res_verdict = bbc_pkg::VERDICT_UNOPENED;
							res_line    = sat_line(line_q);
							err_d       = 1'b1;
						end else if (top_kind != op_entry.kind) begin
							emit         = 1'b1;
							res_verdict  = bbc_pkg::VERDICT_MISMATCH;
							res_expected = closer_of(top_kind);
							res_line     = sat_line(line_q);
							err_d        = 1'b1;
						end else begin
							top_d   = rd_q;
							count_d = count_q - CW'(1);
						end
					end
				end
				bbc_pkg::OP_NEWLINE: begin
					if (!err_q && (line_q != '1)) begin
						line_d = line_q + LINE_BITS'(1);
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	// next-to-top prefetch address follows the updated depth
	assign raddr_full = count_d - CW'(2);
	assign raddr      = raddr_full[AW-1:0];

	// stack memory: write on push, registered read of next-to-top
	always_ff @(posedge clk) begin
		if (push_en) begin
			stack_mem[count_q[AW-1:0]] <= top_d;
		end
		rd_q  <= stack_mem[raddr];
		top_q <= top_d;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			line_q      <= LINE_BITS'(1);
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			line_q  <= line_d;
			err_q   <= err_d;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (emit) begin
			verdict_q  <= res_verdict;
			expected_q <= res_expected;
			line_out_q <= res_line;
		end
	end

	assign out_valid     = out_valid_q;
	assign verdict       = verdict_q;
	assign expected_char = expected_q;
	assign error_line    = line_out_q;

endmodule

>>> rtl/core/bracket_balance_checker.sv
// Bracket balance checker: bytes pass the front beat register and the operation queue
// before the result register; one byte is taken every cycle while nothing stalls, set
// by the push or pop on the stack memory with its registered next-to-top read.
// Asynchronous active-low reset clears the depth, error flag, queue and result valid,
// and sets the line counter to one; stack memory is not cleared and needs no pass.
module bracket_balance_checker #(
	parameter int STACK_DEPTH = 64,
	parameter int LINE_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  verdict,
	output logic [7:0]  expected_char,
	output logic [15:0] error_line
);

	logic             f_valid;
	logic             f_ready;
	bbc_pkg::bbc_op_t f_entry;
	logic             b_valid;
	logic             b_ready;
	bbc_pkg::bbc_op_t b_entry;

	// byte intake and classification
	bbc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.op_valid    (f_valid),
		.op_ready    (f_ready),
		.op_entry    (f_entry)
	);

	// operation queue
	bbc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_entry),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_entry)
	);

	// stack execution and results
	bbc_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.LINE_BITS   (LINE_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.op_valid      (b_valid),
		.op_ready      (b_ready),
		.op_entry      (b_entry),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.verdict       (verdict),
		.expected_char (expected_char),
		.error_line    (error_line)
	);

`ifndef NO_ASSERTIONS
	// balanced verdict carries no character and no line
	a_balanced_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (verdict == bbc_pkg::VERDICT_BALANCED)) |->
		((expected_char == bbc_pkg::CH_NONE) && (error_line == 16'd0)))
		else $error("balanced verdict with nonzero detail");

	// errors without an opener on top report no expected closer
	a_no_closer: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ((verdict == bbc_pkg::VERDICT_UNOPENED) ||
		(verdict == bbc_pkg::VERDICT_TOO_DEEP))) |->
		(expected_char == bbc_pkg::CH_NONE))
		else $error("expected closer reported without opener");

	// verdicts tied to an opener report a real closer
	a_real_closer: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ((verdict == bbc_pkg::VERDICT_MISMATCH) ||
		(verdict == bbc_pkg::VERDICT_UNCLOSED))) |->
		((expected_char == bbc_pkg::CH_RPAREN) || (expected_char == bbc_pkg::CH_RBRACK) ||
		(expected_char == bbc_pkg::CH_RBRACE)))
		else $error("bad expected closer");

	// an operation is consumed only when the result register can take a beat
	a_back_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(b_valid && b_ready) |-> (!out_valid || out_ready))
		else $error("operation consumed while result blocked");
`endif

endmodule

>>> dv/bracket_balance_checker_test.sv
// self-checking testbench of the bracket balance checker with its own verdict predictor
module bracket_balance_checker_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NEST_DEPTH  = 64;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 500;
	localparam int PHASE_ITEMS = 240;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       eot;
	} text_beat_t;

	typedef struct packed {
		logic [2:0]  verdict;
		logic [7:0]  closer;
		logic [15:0] line;
	} verdict_t;

	typedef enum int {
		SHAPE_NOISE,
		SHAPE_BALANCED,
		SHAPE_UNCLOSED,
		SHAPE_MISMATCH,
		SHAPE_EXTRA,
		SHAPE_OVERFLOW,
		SHAPE_FULL
	} text_shape_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  text_byte = '0;
	logic        end_of_text = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  verdict;
	logic [7:0]  expected_char;
	logic [15:0] error_line;

	// pending text beats and verdicts still due
	text_beat_t text_q[$];
	verdict_t   verdict_q[$];
	text_beat_t next_beat;
	int         items_made = 0;
	int         fail_count = 0;

	// idling and phase control
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int phase_id = 0;
	int hold_left = 0;
	bit hold_done = 0;
	int stall_cycles = 0;

	// predictor state
	logic [1:0]  nest_kind [NEST_DEPTH];
	logic [15:0] nest_line [NEST_DEPTH];
	int          nest_depth = 0;
	logic [15:0] cur_line = 16'd1;
	bit          halted = 0;

	bracket_balance_checker i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.text_byte     (text_byte),
		.end_of_text   (end_of_text),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.verdict       (verdict),
		.expected_char (expected_char),
		.error_line    (error_line)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// bracket classification
	function automatic logic [1:0] opener_kind(input logic [7:0] ch);
		case (ch)
			bbc_pkg::CH_LPAREN: return bbc_pkg::KIND_PAREN;
			bbc_pkg::CH_LBRACK: return bbc_pkg::KIND_BRACK;
			bbc_pkg::CH_LBRACE: return bbc_pkg::KIND_BRACE;
			default:            return bbc_pkg::KIND_NONE;
		endcase
	endfunction

	function automatic logic [1:0] closer_kind(input logic [7:0] ch);
		case (ch)
			bbc_pkg::CH_RPAREN: return bbc_pkg::KIND_PAREN;
			bbc_pkg::CH_RBRACK: return bbc_pkg::KIND_BRACK;
			bbc_pkg::CH_RBRACE: return bbc_pkg::KIND_BRACE;
			default:            return bbc_pkg::KIND_NONE;
		endcase
	endfunction

	function automatic logic [7:0] opener_char(input logic [1:0] kind);
		case (kind)
			bbc_pkg::KIND_PAREN: return bbc_pkg::CH_LPAREN;
			bbc_pkg::KIND_BRACK: return bbc_pkg::CH_LBRACK;
			bbc_pkg::KIND_BRACE: return bbc_pkg::CH_LBRACE;
			default:             return bbc_pkg::CH_NONE;
		endcase
	endfunction

	function automatic logic [7:0] closer_char(input logic [1:0] kind);
		case (kind)
			bbc_pkg::KIND_PAREN: return bbc_pkg::CH_RPAREN;
			bbc_pkg::KIND_BRACK: return bbc_pkg::CH_RBRACK;
			bbc_pkg::KIND_BRACE: return bbc_pkg::CH_RBRACE;
			default:             return bbc_pkg::CH_NONE;
		endcase
	endfunction

	// advance the predictor by one accepted beat
	task automatic predict_beat(input logic [7:0] ch, input logic eot);
		verdict_t res;
		logic [1:0] top;
		res = '0;
		if (eot) begin
			if (!halted) begin
				if (nest_depth == 0) begin
					res.verdict = bbc_pkg::VERDICT_BALANCED;
					res.closer  = bbc_pkg::CH_NONE;
					res.line    = 16'd0;
				end else begin
					res.verdict = bbc_pkg::VERDICT_UNCLOSED;
					res.closer  = closer_char(nest_kind[nest_depth - 1]);
					res.line    = nest_line[nest_depth - 1];
				end
				verdict_q.push_back(res);
			end
			nest_depth = 0;
			cur_line   = 16'd1;
			halted     = 0;
		end else if (!halted) begin
			if (opener_kind(ch) != bbc_pkg::KIND_NONE) begin
				if (nest_depth >= NEST_DEPTH) begin
					res.verdict = bbc_pkg::VERDICT_TOO_DEEP;
					res.closer  = bbc_pkg::CH_NONE;
					res.line    = cur_line;
					verdict_q.push_back(res);
					halted = 1;
				end else begin
					nest_kind[nest_depth] = opener_kind(ch);
					nest_line[nest_depth] = cur_line;
					nest_depth++;
				end
			end else if (closer_kind(ch) != bbc_pkg::KIND_NONE) begin
				if (nest_depth == 0) begin
					res.verdict = bbc_pkg::VERDICT_UNOPENED;
					res.closer  = bbc_pkg::CH_NONE;
					res.line    = cur_line;
					verdict_q.push_back(res);
					halted = 1;
				end else begin
					top = nest_kind[nest_depth - 1];
					if (top != closer_kind(ch)) begin
						res.verdict = bbc_pkg::VERDICT_MISMATCH;
						res.closer  = closer_char(top);
						res.line    = cur_line;
						verdict_q.push_back(res);
						halted = 1;
					end else begin
						nest_depth--;
					end
				end
			end else if (ch == bbc_pkg::CH_NEWLINE && cur_line != '1) begin
				cur_line++;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// compare one verdict beat with the oldest one due
	task automatic check_verdict();
		verdict_t want;
		if (verdict_q.size() == 0) begin
			report_mismatch("verdict beat with none due", int'(verdict), -1);
			return;
		end
		want = verdict_q.pop_front();
		if (verdict !== want.verdict)
			report_mismatch("verdict", int'(verdict), int'(want.verdict));
		if (expected_char !== want.closer)
			report_mismatch("expected_char", int'(expected_char), int'(want.closer));
		if (error_line !== want.line)
			report_mismatch("error_line", int'(error_line), int'(want.line));
	endtask

	// driver: offers text beats, holds them until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			text_byte   <= '0;
			end_of_text <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				predict_beat(text_byte, end_of_text);
			if (!in_valid || in_ready) begin
				if (text_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					next_beat = text_q.pop_front();
					in_valid    <= 1'b1;
					text_byte   <= next_beat.text_byte;
					end_of_text <= next_beat.eot;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: takes verdict beats, with random stalls and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_verdict();
			if (phase_id == 2 && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic add_byte(input logic [7:0] b);
		text_beat_t beat;
		beat.text_byte = b;
		beat.eot       = 1'b0;
		text_q.push_back(beat);
		items_made++;
	endtask

	// end of text carries a random, ignored byte
	task automatic add_eot();
		text_beat_t beat;
		beat.text_byte = 8'($urandom_range(255));
		beat.eot       = 1'b1;
		text_q.push_back(beat);
		items_made++;
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (opener_kind(b) != bbc_pkg::KIND_NONE || closer_kind(b) != bbc_pkg::KIND_NONE);
		return b;
	endfunction

	function automatic text_shape_t pick_shape();
		int r;
		r = $urandom_range(99);
		if (r < 8)  return SHAPE_NOISE;
		if (r < 50) return SHAPE_BALANCED;
		if (r < 64) return SHAPE_UNCLOSED;
		if (r < 78) return SHAPE_MISMATCH;
		if (r < 90) return SHAPE_EXTRA;
		if (r < 95) return SHAPE_OVERFLOW;
		return SHAPE_FULL;
	endfunction

	// one text: a well-nested random body, then an ending of the given shape
	task automatic add_random_text(input text_shape_t shape);
		logic [1:0] open_k[$];
		logic [1:0] k;
		int len;
		int r;
		len = $urandom_range(24, 1);
		if (shape == SHAPE_NOISE) begin
			repeat (len) add_byte(8'($urandom_range(255)));
			add_eot();
			return;
		end
		repeat (len) begin
			r = $urandom_range(9);
			if (r < 4 && open_k.size() < NEST_DEPTH) begin
				k = 2'($urandom_range(2));
				open_k.push_back(k);
				add_byte(opener_char(k));
			end else if (r < 7 && open_k.size() > 0) begin
				add_byte(closer_char(open_k.pop_back()));
			end else if (r == 7) begin
				add_byte(bbc_pkg::CH_NEWLINE);
			end else begin
				add_byte(plain_byte());
			end
		end
		case (shape)
			SHAPE_BALANCED, SHAPE_EXTRA: begin
				while (open_k.size() > 0) begin
					if ($urandom_range(3) == 0)
						add_byte(bbc_pkg::CH_NEWLINE);
					add_byte(closer_char(open_k.pop_back()));
				end
				if (shape == SHAPE_EXTRA)
					add_byte(closer_char(2'($urandom_range(2))));
			end
			SHAPE_UNCLOSED: begin
				if (open_k.size() == 0)
					add_byte(opener_char(2'($urandom_range(2))));
			end
			SHAPE_MISMATCH: begin
				if (open_k.size() == 0) begin
					k = 2'($urandom_range(2));
					open_k.push_back(k);
					add_byte(opener_char(k));
				end
				r = (int'(open_k[$]) + 1 + int'($urandom_range(1))) % 3;
				add_byte(closer_char(2'(r)));
			end
			default: begin
				// fill the stack to its last entry
				while (open_k.size() < NEST_DEPTH) begin
					if ($urandom_range(7) == 0)
						add_byte($urandom_range(1) ? bbc_pkg::CH_NEWLINE : plain_byte());
					k = 2'($urandom_range(2));
					open_k.push_back(k);
					add_byte(opener_char(k));
				end
				if (shape == SHAPE_OVERFLOW)
					add_byte(opener_char(2'($urandom_range(2))));
			end
		endcase
		// bytes after an error must be ignored
		if (shape == SHAPE_MISMATCH || shape == SHAPE_EXTRA || shape == SHAPE_OVERFLOW)
			repeat ($urandom_range(4))
				add_byte($urandom_range(1) ? bbc_pkg::CH_NEWLINE : 8'($urandom_range(255)));
		add_eot();
	endtask

	task automatic set_phase(input int p, input int send_pct, input int recv_pct);
		@(negedge clk);
		phase_id      = p;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	// wait until every beat is taken and every verdict has arrived
	task automatic drain();
		while (text_q.size() > 0 || in_valid || verdict_q.size() > 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int target;
		send_idle_pct = 6;
		recv_idle_pct = 82;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty text, every bracket, extremes of the byte
		add_eot();
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(bbc_pkg::CH_LPAREN);
		add_byte(bbc_pkg::CH_RPAREN);
		add_byte(bbc_pkg::CH_LBRACK);
		add_byte(bbc_pkg::CH_RBRACK);
		add_byte(bbc_pkg::CH_LBRACE);
		add_byte(bbc_pkg::CH_RBRACE);
		add_eot();
		// mismatched closer on line two, then ignored bytes
		add_byte(bbc_pkg::CH_LPAREN);
		add_byte(bbc_pkg::CH_NEWLINE);
		add_byte(bbc_pkg::CH_RBRACK);
		add_byte(bbc_pkg::CH_RBRACE);
		add_byte(bbc_pkg::CH_NEWLINE);
		add_eot();
		// closer with nothing open, line count back at one
		add_byte(bbc_pkg::CH_RBRACE);
		add_eot();
		// innermost opener left unclosed
		add_byte(bbc_pkg::CH_LBRACK);
		add_byte(bbc_pkg::CH_LBRACE);
		add_eot();

		// sender mostly busy, receiver mostly stalled
		target = items_made + PHASE_ITEMS;
		add_random_text(SHAPE_OVERFLOW);
		while (items_made < target)
			add_random_text(pick_shape());
		drain();

		// the other way round
		set_phase(1, 82, 6);
		target = items_made + PHASE_ITEMS;
		add_random_text(SHAPE_FULL);
		while (items_made < target)
			add_random_text(pick_shape());
		drain();

		// no idling; receiver holds off while short texts pile up
		set_phase(2, 0, 0);
		target = items_made + PHASE_ITEMS;
		while (items_made < target)
			add_random_text(pick_shape());
		drain();
		repeat (20) @(negedge clk);

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/bbc_pkg.sv
rtl/core/bbc_front.sv
rtl/core/bbc_queue.sv
rtl/core/bbc_back.sv
rtl/core/bracket_balance_checker.sv
dv/bracket_balance_checker_test.sv
